@@ hw/rtl/lscc_pkg.sv @@
// Shared types and constants for the line sensor centroid classifier.
// Depends on nothing; every module of the block imports it.
package lscc_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int SENSE_W     = 16;
    localparam int B_W         = 16;
    localparam int D_W         = SENSE_W + 1;
    localparam int SQ_W        = 2 * B_W;
    localparam int TOTAL_W     = SQ_W + $clog2(NUM_SENSORS);
    localparam int WSUM_W      = SQ_W + $clog2(NUM_SENSORS * (NUM_SENSORS - 1) / 2);
    localparam int DEN_W       = TOTAL_W + $clog2(NUM_SENSORS);
    localparam int DIV_W       = DEN_W + 1;
    localparam int Q_W         = 16;
    localparam int NUM_W       = WSUM_W + Q_W + 1;
    localparam int SQT_W       = 35;
    localparam int STEER_W     = 16;
    localparam int PAIRS       = (NUM_SENSORS + 1) / 2;
    localparam int ONE_Q14     = 16384;

    localparam logic [SQT_W-1:0] INTERSECTION_RESET = SQT_W'(214748);
    localparam logic [SQT_W-1:0] TURN_RESET         = SQT_W'(4295);
    localparam logic [B_W-1:0]   NOLINE_RESET       = B_W'(7);

    typedef enum logic [2:0] {
        FEAT_NONE         = 3'd0,
        FEAT_INTERSECTION = 3'd1,
        FEAT_RIGHT        = 3'd2,
        FEAT_LEFT         = 3'd3,
        FEAT_NOLINE       = 3'd4
    } feature_t;

    typedef enum logic [1:0] {
        CFG_INTERSECTION = 2'd0,
        CFG_TURN         = 2'd1,
        CFG_NOLINE       = 2'd2,
        CFG_OFFSET       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SENSE_W-1:0] reading_0;
        logic [SENSE_W-1:0] reading_1;
        logic [SENSE_W-1:0] reading_2;
        logic [SENSE_W-1:0] reading_3;
        logic [SENSE_W-1:0] reading_4;
        logic [SENSE_W-1:0] reading_5;
        logic [SENSE_W-1:0] reading_6;
        logic [SENSE_W-1:0] reading_7;
    } frame_t;

    typedef struct packed {
        logic signed [STEER_W-1:0] steer;
        logic signed [STEER_W-1:0] trimmed_steer;
        logic [2:0]                feature;
        logic [B_W-1:0]            max_brightness;
        logic [SQT_W-1:0]          square_total;
    } result_t;

    // Per-frame figures carried alongside the steer division.
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [B_W-1:0]     bmax;
    } lscc_side_t;

endpackage

@@ hw/rtl/lscc_recip.sv @@
// Pipelined reciprocal: brightness = floor(65536 / (1 + reading)) for every sensor lane.
// One quotient bit per stage; depends on lscc_pkg.
module lscc_recip (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [lscc_pkg::SENSE_W-1:0] reading [lscc_pkg::NUM_SENSORS],
    output logic                        out_valid,
    output logic [lscc_pkg::B_W-1:0]    bright [lscc_pkg::NUM_SENSORS]
);
    import lscc_pkg::*;

    localparam int STEPS = D_W;

    logic [STEPS:0]   valid_reg;
    logic [D_W-1:0]   div_reg [0:STEPS][NUM_SENSORS];
    logic [D_W-1:0]   rem_reg [0:STEPS][NUM_SENSORS];
    logic [D_W-1:0]   quo_reg [0:STEPS][NUM_SENSORS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < NUM_SENSORS; l++)
            begin
                div_reg[0][l] <= D_W'(reading[l]) + D_W'(1);
                rem_reg[0][l] <= '0;
                quo_reg[0][l] <= '0;
            end
        end
    end

    // The dividend is the constant 2^B_W, so only its top bit is set.
    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        for (genvar l = 0; l < NUM_SENSORS; l++)
        begin : g_lane
            logic [D_W:0]   shifted;
            logic           ge;
            logic [D_W-1:0] rem_next;

            assign shifted  = {rem_reg[s][l], ((D_W - 1 - s) == B_W) ? 1'b1 : 1'b0};
            assign ge       = shifted >= {1'b0, div_reg[s][l]};
            assign rem_next = ge ? D_W'(shifted - {1'b0, div_reg[s][l]}) : shifted[D_W-1:0];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    div_reg[s+1][l] <= div_reg[s][l];
                    rem_reg[s+1][l] <= rem_next;
                    quo_reg[s+1][l] <= {quo_reg[s][l][D_W-2:0], ge};
                end
            end
        end
    end

    // Only a zero reading gives 65536, which saturates.
    always_comb
    begin
        for (int l = 0; l < NUM_SENSORS; l++)
        begin
            bright[l] = quo_reg[STEPS][l][B_W] ? '1 : quo_reg[STEPS][l][B_W-1:0];
        end
    end

    assign out_valid = valid_reg[STEPS];

endmodule

@@ hw/rtl/lscc_accum.sv @@
// Squares, maximum and the plain and position-weighted sums of squared brightness.
// Three register stages; depends on lscc_pkg.
module lscc_accum (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [lscc_pkg::B_W-1:0]   bright [lscc_pkg::NUM_SENSORS],
    output logic                       out_valid,
    output lscc_pkg::lscc_side_t       side,
    output logic [lscc_pkg::WSUM_W-1:0] wsum
);
    import lscc_pkg::*;

    logic [2:0]          valid_reg;
    logic [SQ_W-1:0]     sq_reg [NUM_SENSORS];
    logic [B_W-1:0]      bmax1_reg;
    logic [B_W-1:0]      bmax2_reg;
    logic [TOTAL_W-1:0]  tpair_reg [PAIRS];
    logic [WSUM_W-1:0]   wpair_reg [PAIRS];
    logic [B_W-1:0]      bmax_next;
    logic [TOTAL_W-1:0]  tpair_next [PAIRS];
    logic [WSUM_W-1:0]   wpair_next [PAIRS];
    logic [TOTAL_W-1:0]  total_next;
    logic [WSUM_W-1:0]   wsum_next;
    lscc_side_t          side_reg;
    logic [WSUM_W-1:0]   wsum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_comb
    begin
        bmax_next = '0;
        for (int l = 0; l < NUM_SENSORS; l++)
        begin
            if (bright[l] > bmax_next)
            begin
                bmax_next = bright[l];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < PAIRS; k++)
        begin
            tpair_next[k] = TOTAL_W'(sq_reg[2*k]);
            wpair_next[k] = WSUM_W'(sq_reg[2*k]) * WSUM_W'(2*k);
            if (2*k + 1 < NUM_SENSORS)
            begin
                tpair_next[k] = tpair_next[k] + TOTAL_W'(sq_reg[2*k+1]);
                wpair_next[k] = wpair_next[k] + WSUM_W'(sq_reg[2*k+1]) * WSUM_W'(2*k + 1);
            end
        end
    end

    always_comb
    begin
        total_next = '0;
        wsum_next  = '0;
        for (int k = 0; k < PAIRS; k++)
        begin
            total_next = total_next + tpair_reg[k];
            wsum_next  = wsum_next + wpair_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < NUM_SENSORS; l++)
            begin
                sq_reg[l] <= bright[l] * bright[l];
            end
            bmax1_reg <= bmax_next;
            tpair_reg <= tpair_next;
            wpair_reg <= wpair_next;
            bmax2_reg <= bmax1_reg;
            side_reg.total <= total_next;
            side_reg.bmax  <= bmax2_reg;
            wsum_reg       <= wsum_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign side      = side_reg;
    assign wsum      = wsum_reg;

endmodule

@@ hw/rtl/lscc_steer_div.sv @@
// Pipelined restoring divider for the centroid: (65536*wsum + den) / (2*den), den = 7*total.
// Two set-up stages then one quotient bit per stage; depends on lscc_pkg.
module lscc_steer_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  lscc_pkg::lscc_side_t        in_side,
    input  logic [lscc_pkg::WSUM_W-1:0] wsum,
    output logic                        out_valid,
    output lscc_pkg::lscc_side_t        out_side,
    output logic [lscc_pkg::Q_W-1:0]    quotient
);
    import lscc_pkg::*;

    localparam int LAST = Q_W + 1;

    logic [LAST:0]      valid_reg;
    lscc_side_t         side_reg [0:LAST];
    logic [WSUM_W-1:0]  wsum0_reg;
    logic [DEN_W-1:0]   den0_reg;
    logic [NUM_W-1:0]   num;
    logic [DIV_W-1:0]   rem_reg [1:LAST];
    logic [DIV_W-1:0]   dvs_reg [1:LAST];
    logic [Q_W-1:0]     low_reg [1:LAST];
    logic [Q_W-1:0]     quo_reg [1:LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAST-1:0], in_valid};
        end
    end

    assign num = NUM_W'({wsum0_reg, {Q_W{1'b0}}}) + NUM_W'(den0_reg);

    // The quotient never exceeds 32768, so the upper dividend bits start below the divisor.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den0_reg    <= DEN_W'(in_side.total) * DEN_W'(NUM_SENSORS - 1);
            wsum0_reg   <= wsum;
            side_reg[0] <= in_side;
            side_reg[1] <= side_reg[0];
            rem_reg[1]  <= DIV_W'(num[NUM_W-1:Q_W]);
            low_reg[1]  <= num[Q_W-1:0];
            dvs_reg[1]  <= {den0_reg, 1'b0};
            quo_reg[1]  <= '0;
        end
    end

    for (genvar s = 1; s <= Q_W; s++)
    begin : g_step
        logic [DIV_W:0]   shifted;
        logic             ge;
        logic [DIV_W-1:0] rem_next;

        assign shifted  = {rem_reg[s], low_reg[s][Q_W-s]};
        assign ge       = shifted >= {1'b0, dvs_reg[s]};
        assign rem_next = ge ? DIV_W'(shifted - {1'b0, dvs_reg[s]}) : shifted[DIV_W-1:0];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[s+1] <= side_reg[s];
                rem_reg[s+1]  <= rem_next;
                dvs_reg[s+1]  <= dvs_reg[s];
                low_reg[s+1]  <= low_reg[s];
                quo_reg[s+1]  <= {quo_reg[s][Q_W-2:0], ge};
            end
        end
    end

    assign out_valid = valid_reg[LAST];
    assign out_side  = side_reg[LAST];
    assign quotient  = quo_reg[LAST];

endmodule

@@ hw/rtl/line_sensor_centroid_classifier.sv @@
// The pipeline has 41 register stages: 18 in the reciprocal (an input register and 17 quotient
// bits), 3 in the accumulator, 18 in the centroid divider (two set-up stages and 16
// quotient bits) and 2 finishing stages.
// Throughput: one frame per cycle; a stalled result freezes the whole pipeline in place.
// Reset: rst_n clears every valid bit and loads the register defaults at once.
module line_sensor_centroid_classifier (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             frame_valid,
    output logic                             frame_stall,
    input  lscc_pkg::frame_t                 frame,
    output logic                             result_valid,
    input  logic                             result_stall,
    output lscc_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  lscc_pkg::cfg_index_t             cfg_index,
    input  logic [lscc_pkg::SQT_W-1:0]       cfg_data
);
    import lscc_pkg::*;

    // The pipeline advances whenever the output register is empty or being taken.
    logic                      adv;
    logic [SENSE_W-1:0]        reading [NUM_SENSORS];
    logic                      recip_valid;
    logic [B_W-1:0]            bright [NUM_SENSORS];
    logic                      acc_valid;
    lscc_side_t                acc_side;
    logic [WSUM_W-1:0]         acc_wsum;
    logic                      div_valid;
    lscc_side_t                div_side;
    logic [Q_W-1:0]            quotient;

    logic [SQT_W-1:0]          int_th_reg;
    logic [SQT_W-1:0]          turn_th_reg;
    logic [B_W-1:0]            noline_th_reg;
    logic signed [STEER_W-1:0] offset_reg;

    logic                      fin_valid_reg;
    logic signed [STEER_W-1:0] steer_reg;
    logic [SQT_W-1:0]          tsat_reg;
    logic [B_W-1:0]            bmax_reg;
    logic signed [STEER_W-1:0] steer_next;
    logic [SQT_W-1:0]          tsat_next;
    logic [TOTAL_W+SQT_W-1:0]  total_wide;

    logic                      result_valid_reg;
    result_t                   result_reg;
    logic signed [STEER_W:0]   drive_raw;
    logic signed [STEER_W-1:0] drive_next;
    feature_t                  feature_next;

    assign adv         = !(result_valid_reg && result_stall);
    assign frame_stall = !adv;
    assign cfg_ready   = 1'b1;

    assign reading[0] = frame.reading_0;
    assign reading[1] = frame.reading_1;
    assign reading[2] = frame.reading_2;
    assign reading[3] = frame.reading_3;
    assign reading[4] = frame.reading_4;
    assign reading[5] = frame.reading_5;
    assign reading[6] = frame.reading_6;
    assign reading[7] = frame.reading_7;

    lscc_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (frame_valid),
        .reading   (reading),
        .out_valid (recip_valid),
        .bright    (bright)
    );

    lscc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (recip_valid),
        .bright    (bright),
        .out_valid (acc_valid),
        .side      (acc_side),
        .wsum      (acc_wsum)
    );

    lscc_steer_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (acc_valid),
        .in_side   (acc_side),
        .wsum      (acc_wsum),
        .out_valid (div_valid),
        .out_side  (div_side),
        .quotient  (quotient)
    );

    // Configuration registers. Writes must arrive only while no frame is in flight; unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_th_reg    <= INTERSECTION_RESET;
            turn_th_reg   <= TURN_RESET;
            noline_th_reg <= NOLINE_RESET;
            offset_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INTERSECTION: int_th_reg    <= cfg_data;
                CFG_TURN:         turn_th_reg   <= cfg_data;
                CFG_NOLINE:       noline_th_reg <= cfg_data[B_W-1:0];
                CFG_OFFSET:       offset_reg    <= $signed(cfg_data[STEER_W-1:0]);
                default:          offset_reg    <= offset_reg;
            endcase
        end
    end

    // First finishing stage: centre the quotient and saturate the total to the output width.
    // A zero total cannot arise since every brightness is at least one, but it yields zero steer.
    assign total_wide = (TOTAL_W+SQT_W)'(div_side.total);

    always_comb
    begin
        if (div_side.total == '0)
        begin
            steer_next = '0;
        end
        else
        begin
            steer_next = STEER_W'($signed({1'b0, quotient}) - (Q_W+1)'(ONE_Q14));
        end
        if (total_wide > (TOTAL_W+SQT_W)'({SQT_W{1'b1}}))
        begin
            tsat_next = '1;
        end
        else
        begin
            tsat_next = total_wide[SQT_W-1:0];
        end
    end

    // Second finishing stage: offset, clamp and classify. A turn whose steer rounds to zero
    // counts as a left turn.
    assign drive_raw = $signed({steer_reg[STEER_W-1], steer_reg})
                     - $signed({offset_reg[STEER_W-1], offset_reg});

    always_comb
    begin
        if (drive_raw > (STEER_W+1)'(ONE_Q14))
        begin
            drive_next = STEER_W'(ONE_Q14);
        end
        else if (drive_raw < -(STEER_W+1)'(ONE_Q14))
        begin
            drive_next = -STEER_W'(ONE_Q14);
        end
        else
        begin
            drive_next = drive_raw[STEER_W-1:0];
        end

        if (tsat_reg > int_th_reg)
        begin
            feature_next = FEAT_INTERSECTION;
        end
        else if (tsat_reg > turn_th_reg)
        begin
            feature_next = (steer_reg > 0) ? FEAT_RIGHT : FEAT_LEFT;
        end
        else if (bmax_reg < noline_th_reg)
        begin
            feature_next = FEAT_NOLINE;
        end
        else
        begin
            feature_next = FEAT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fin_valid_reg    <= div_valid;
            result_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            steer_reg                 <= steer_next;
            tsat_reg                  <= tsat_next;
            bmax_reg                  <= div_side.bmax;
            result_reg.steer          <= steer_reg;
            result_reg.trimmed_steer  <= drive_next;
            result_reg.feature        <= feature_next;
            result_reg.max_brightness <= bmax_reg;
            result_reg.square_total   <= tsat_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Every brightness is at least one, so a delivered transaction never has a zero total.
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.square_total != '0)
        else $error("zero square total delivered");

    a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.trimmed_steer <= 16'sd16384
                          && result.trimmed_steer >= -16'sd16384))
        else $error("trimmed steer outside plus or minus one");

    a_intersection_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.feature == FEAT_INTERSECTION
        |-> result.square_total > int_th_reg)
        else $error("intersection reported below threshold");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(steer_reg))
        else $error("pipeline moved while the output was stalled");

endmodule
